// ----- hdl/rsn_pkg.sv -----
// Shared types, widths and constants of the rebin, sum and normalize block.
package rsn_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FACTOR_W = 11;
  localparam int WIDTH_W  = 24;
  localparam int SUM_W    = 34;
  localparam int TOTAL_W  = 40;
  localparam int DEN_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int CFG_W    = 24;

  localparam int MAX_BINS_DEF = 64;
  localparam int MAX_REBIN    = 1024;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [FACTOR_W-1:0] REBIN_RESET = 11'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET = 24'd65536;

  typedef enum logic [0:0] {
    REG_REBIN = 1'b0,
    REG_WIDTH = 1'b1
  } cfg_reg_e;

  // One request from the front end: a closed group, the end of a series, or both.
  typedef struct packed {
    logic             close;
    logic             last;
    logic [SUM_W-1:0] sum;
  } rsn_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               norm;
    logic               ovf;
  } rsn_res_t;

  typedef enum logic [2:0] {
    BK_COLLECT,
    BK_MUL,
    BK_SUM,
    BK_READ,
    BK_LOAD,
    BK_DIV,
    BK_EMIT
  } bk_state_e;

endpackage

// ----- hdl/rsn_front.sv -----
// Front end: sums samples into groups and issues a request per closed group or series end.
module rsn_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [rsn_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic                            last_i,
  input  logic [rsn_pkg::FACTOR_W-1:0]    factor_i,
  input  logic                            full_i,
  output logic                            push_o,
  output rsn_pkg::rsn_req_t               req_o
);
  import rsn_pkg::*;

  localparam logic [16:0] MaxRebinW = 17'(MAX_REBIN);

  logic [SUM_W-1:0]    accum_q, accum_d, sum_new;
  logic [FACTOR_W-1:0] cnt_q, cnt_d, cnt_new, factor;
  logic                accept, close;

  // A zero factor counts as one; a large factor is capped.
  always_comb begin
    if (factor_i == '0) begin
      factor = FACTOR_W'(1);
    end else if ({6'b0, factor_i} > MaxRebinW) begin
      factor = MaxRebinW[FACTOR_W-1:0];
    end else begin
      factor = factor_i;
    end
  end

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign sum_new = accum_q + SUM_W'(sample_i);
  assign cnt_new = cnt_q + FACTOR_W'(1);
  assign close   = cnt_new >= factor;

  assign push_o    = accept && (close || last_i);
  assign req_o.close = close;
  assign req_o.last  = last_i;
  assign req_o.sum   = sum_new;

  always_comb begin
    accum_d = accum_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (close || last_i) begin
        accum_d = '0;
        cnt_d   = '0;
      end else begin
        accum_d = sum_new;
        cnt_d   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      cnt_q   <= '0;
    end else begin
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- hdl/rsn_queue.sv -----
// Short request queue between the front end and the back end.
module rsn_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsn_pkg::rsn_req_t req_i,
  output logic              full_o,
  output logic              valid_o,
  output rsn_pkg::rsn_req_t head_o,
  input  logic              pop_i
);
  import rsn_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  rsn_req_t        entry_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   num_q, num_d;
  logic            do_push, do_pop;

  assign full_o  = num_q == NW'(QUEUE_DEPTH);
  assign valid_o = num_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    num_d    = num_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      num_d = num_q + NW'(1);
    end else if (do_pop && !do_push) begin
      num_d = num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      num_q    <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

// ----- hdl/rsn_div.sv -----
// Radix-2 fractional divider: floor(num * 2^32 / den), saturating, one bit per cycle.
module rsn_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rsn_pkg::SUM_W-1:0]    num_i,
  input  logic [rsn_pkg::DEN_W-1:0]    den_i,
  output logic                         done_o,
  output logic [rsn_pkg::VALUE_W-1:0]  quot_o
);
  import rsn_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W-1:0]   rem_q, den_q;
  logic [VALUE_W-1:0] quot_q;
  logic [DEN_W:0]     two_r, diff;
  logic               ge, sat;

  // The remainder always stays below the divisor, so doubling it fits one extra bit.
  assign two_r = {rem_q, 1'b0};
  assign diff  = two_r - {1'b0, den_q};
  assign ge    = two_r >= {1'b0, den_q};
  assign sat   = {{(DEN_W - SUM_W){1'b0}}, num_i} >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= CNT_W'(VALUE_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= {{(DEN_W - SUM_W){1'b0}}, num_i};
      quot_q <= sat ? '1 : '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : two_r[DEN_W-1:0];
      quot_q <= {quot_q[VALUE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hdl/rsn_back.sv -----
// Back end: stores bins, forms the area, normalizes each bin by a nonzero area, drives the result register.
module rsn_back #(
  parameter int MAX_BINS = rsn_pkg::MAX_BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  rsn_pkg::rsn_req_t             q_head_i,
  output logic                          q_pop_o,
  input  logic [rsn_pkg::WIDTH_W-1:0]   bin_width_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rsn_pkg::rsn_res_t             out_o
);
  import rsn_pkg::*;

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = $clog2(MAX_BINS + 1);

  bk_state_e            state_q, state_d;
  logic [CW-1:0]        filled_q, filled_d, filled_n, k_q, k_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic                 dropped_q, dropped_d;
  logic [47:0]          prod_lo_q, prod_lo_d;
  logic [39:0]          prod_hi_q, prod_hi_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [SUM_W-1:0]     mem_q [MAX_BINS];
  logic [SUM_W-1:0]     rd_q;
  logic                 wr_en, rd_en, store, norm, last_k, slot_free, out_load;
  logic                 div_start, div_done;
  logic [VALUE_W-1:0]   div_quot;
  logic                 out_valid_q;
  rsn_res_t             out_q;

  assign store     = q_head_i.close && (filled_q < CW'(MAX_BINS));
  assign filled_n  = store ? filled_q + CW'(1) : filled_q;
  assign norm      = den_q != '0;
  assign last_k    = (k_q + CW'(1)) == filled_q;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    filled_d  = filled_q;
    total_d   = total_q;
    dropped_d = dropped_q;
    k_d       = k_q;
    prod_lo_d = prod_lo_q;
    prod_hi_d = prod_hi_q;
    den_d     = den_q;
    val_d     = val_q;
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_COLLECT: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (store) begin
            wr_en    = 1'b1;
            filled_d = filled_n;
            total_d  = total_q + TOTAL_W'(q_head_i.sum);
          end else if (q_head_i.close) begin
            dropped_d = 1'b1;
          end
          if (q_head_i.last) begin
            if (filled_n == '0) begin
              dropped_d = 1'b0;
            end else begin
              k_d     = '0;
              state_d = BK_MUL;
            end
          end
        end
      end
      BK_MUL: begin
        prod_lo_d = total_q[23:0] * bin_width_i;
        prod_hi_d = total_q[TOTAL_W-1:24] * bin_width_i;
        state_d   = BK_SUM;
      end
      BK_SUM: begin
        den_d   = {16'b0, prod_lo_q} + {prod_hi_q, 24'b0};
        state_d = BK_READ;
      end
      BK_READ: begin
        rd_en   = 1'b1;
        state_d = BK_LOAD;
      end
      BK_LOAD: begin
        if (norm) begin
          div_start = 1'b1;
          state_d   = BK_DIV;
        end else begin
          val_d   = (rd_q[SUM_W-1:VALUE_W] != '0) ? '1 : rd_q[VALUE_W-1:0];
          state_d = BK_EMIT;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          val_d   = div_quot;
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (last_k) begin
            filled_d  = '0;
            total_d   = '0;
            dropped_d = 1'b0;
            state_d   = BK_COLLECT;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_COLLECT;
      filled_q    <= '0;
      total_q     <= '0;
      dropped_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      total_q     <= total_d;
      dropped_q   <= dropped_d;
      k_q         <= k_d;
      out_valid_q <= out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    den_q     <= den_d;
    val_q     <= val_d;
    if (out_load) begin
      out_q.value <= val_q;
      out_q.index <= INDEX_W'(k_q);
      out_q.last  <= last_k;
      out_q.norm  <= norm;
      out_q.ovf   <= dropped_q;
    end
  end

  // Bin store: written at the fill position, read one bin at a time during emission.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[filled_q[AW-1:0]] <= q_head_i.sum;
    end
    if (rd_en) begin
      rd_q <= mem_q[k_q[AW-1:0]];
    end
  end

  rsn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rd_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_filled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CW'(MAX_BINS))
    else $error("bin count exceeds the bin store");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ || state_q == BK_LOAD || state_q == BK_DIV || state_q == BK_EMIT)
      |-> k_q < filled_q)
    else $error("emission index beyond stored bins");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == BK_DIV)
    else $error("divider finished outside the divide state");

  a_series_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT && slot_free && last_k)
      |=> (state_q == BK_COLLECT && filled_q == '0 && !dropped_q))
    else $error("series state not cleared after the final bin");
`endif

endmodule

// ----- hdl/rebin_sum_normalize.sv -----
// Top level of the histogram rebin, sum and unit-area normalize block.
//
// Samples stream in on the slave side, one per cycle, and are summed into bins of
// rebin_factor samples each; a trailing partial group is dropped, and full groups
// past MAX_BINS are dropped and flagged as overflow. The front end takes one sample
// per cycle and hands each closed group, or the end of a series, as a request to a
// two-entry queue; the back end retires one request per cycle while collecting, so
// the slave side runs at full rate until a series ends. When the sample marked last
// arrives, the back end forms the area total * bin_width as two narrow partial products
// and then their sum, and emits every stored bin in order. A normalized bin goes through a
// bin store read, the divider load, the one-bit-per-cycle divider for its 32-bit quotient
// and the result hand-off; an unnormalized bin, emitted when the area is zero, skips the
// divider. While a series is being emitted the front end keeps taking samples until the
// queue holds two requests; then the slave side stalls until the last bin of the previous
// series has gone into the output register and the back end is collecting again. The
// output register lets the back end work on the next bin while a result waits on the
// master side. A last sample with no stored bins produces no result and simply clears
// the series. Configuration is to be written through cfg_we_i, cfg_addr_i and cfg_wdata_i
// only while the block is idle, which the block itself does not enforce: index 0 is
// rebin_factor, index 1 is bin_width (Q8.16).
module rebin_sum_normalize #(
  parameter int MAX_BINS = rsn_pkg::MAX_BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [rsn_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Sample requests.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // [23:0] sample
  input  logic                          s_axis_tlast,
  // Bin results.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,   // [31:0] bin_value, [37:32] bin_index
  output logic [1:0]                    m_axis_tuser,   // [0] normalized, [1] overflow
  output logic                          m_axis_tlast
);
  import rsn_pkg::*;

  logic [FACTOR_W-1:0] rebin_q;
  logic [WIDTH_W-1:0]  width_q;
  logic                push, full, q_valid, q_pop;
  rsn_req_t            req, head;
  rsn_res_t            res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rebin_q <= REBIN_RESET;
      width_q <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_REBIN: rebin_q <= cfg_wdata_i[FACTOR_W-1:0];
        REG_WIDTH: width_q <= cfg_wdata_i[WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rsn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .last_i   (s_axis_tlast),
    .factor_i (rebin_q),
    .full_i   (full),
    .push_o   (push),
    .req_o    (req)
  );

  rsn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (q_pop)
  );

  rsn_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (q_pop),
    .bin_width_i (width_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.index, res.value};
  assign m_axis_tuser = {res.ovf, res.norm};
  assign m_axis_tlast = res.last;

endmodule
